[rtl/core/iwsb_pkg.sv]
// Shared types and constants for the indexed wheel slot blend block.
package iwsb_pkg;

    // Field widths
    localparam int CNT_W   = 5;
    localparam int OFS_W   = 16;
    localparam int ANG_W   = 32;
    localparam int SUM_W   = ANG_W + 1;
    localparam int POS_W   = 4;
    localparam int NUM_W   = 8;
    localparam int CH_W    = 16;
    localparam int WRAP_W  = 15;
    localparam int PH_W    = 16;
    localparam int COORD_W = PH_W + CNT_W;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 1;
    localparam int NUM_CH  = 4;

    // One turn is 23040 = 45 * 512 units
    localparam int TURN_UNITS = 23040;
    localparam int LOW_W      = 9;
    localparam int DIV_BASE   = 45;
    localparam int REM_W      = 6;

    // Angle reduction: biased quotient by reciprocal of 45
    localparam int           X_W       = SUM_W - LOW_W + 1;
    localparam logic [X_W-1:0] X_BIAS  = X_W'(DIV_BASE * (2 ** 18));
    localparam int           RECIP1_SH = 25;
    localparam int           RECIP1_W  = 20;
    localparam logic [RECIP1_W-1:0] RECIP1 = RECIP1_W'((2 ** RECIP1_SH) / DIV_BASE);
    localparam int           Q1_W      = 20;
    localparam int           PROD1_W   = X_W + RECIP1_W;

    // Phase: wrapped * 128 / 45
    localparam int           V_W       = WRAP_W + 7;
    localparam int           RECIP2_SH = 22;
    localparam int           RECIP2_W  = 17;
    localparam logic [RECIP2_W-1:0] RECIP2 = RECIP2_W'((2 ** RECIP2_SH) / DIV_BASE);
    localparam int           PROD2_W   = V_W + RECIP2_W;

    // Blend lanes
    localparam int D_W    = CH_W + 1;
    localparam int BPR_W  = 2 * D_W;

    // Codes
    localparam logic ACT_EVALUATE = 1'b0;
    localparam logic ACT_LOAD     = 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT       = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLACEMENT_OFFSET = 1'b1;

    typedef struct packed {
        logic [NUM_W-1:0] number;
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
        logic [CH_W-1:0]  gain;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

    typedef struct packed {
        logic accept_eval;
        logic write_slot;
        logic div1;
        logic rem1;
        logic div2;
        logic rem2;
        logic scale;
        logic mul;
        logic load_out;
    } t_cmd;

endpackage

[rtl/core/iwsb_ram.sv]
// Generic RAM: one write port, two registered read ports.
module iwsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

[rtl/core/iwsb_ctrl.sv]
// Controller: steps one request through the datapath and owns the output valid.
module iwsb_ctrl import iwsb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_action,
    output logic o_ready,
    output logic o_valid,
    input  logic i_out_ready,
    output t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV1,
        S_REM1,
        S_DIV2,
        S_REM2,
        S_SCALE,
        S_READ,
        S_MUL,
        S_OUT
    } t_state;

    t_state r_state;
    logic   r_out_valid;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;

    always_comb begin
        o_cmd             = '0;
        o_cmd.accept_eval = (r_state == S_IDLE) && i_valid && (i_action == ACT_EVALUATE);
        o_cmd.write_slot  = (r_state == S_IDLE) && i_valid && (i_action == ACT_LOAD);
        o_cmd.div1        = (r_state == S_DIV1);
        o_cmd.rem1        = (r_state == S_REM1);
        o_cmd.div2        = (r_state == S_DIV2);
        o_cmd.rem2        = (r_state == S_REM2);
        o_cmd.scale       = (r_state == S_SCALE);
        o_cmd.mul         = (r_state == S_MUL);
        o_cmd.load_out    = (r_state == S_OUT) && (!r_out_valid || i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_cmd.accept_eval) begin
                        r_state <= S_DIV1;
                    end
                end
                S_DIV1:  r_state <= S_REM1;
                S_REM1:  r_state <= S_DIV2;
                S_DIV2:  r_state <= S_REM2;
                S_REM2:  r_state <= S_SCALE;
                S_SCALE: r_state <= S_READ;
                S_READ:  r_state <= S_MUL;
                S_MUL:   r_state <= S_OUT;
                S_OUT: begin
                    // hold until the output register is free
                    if (o_cmd.load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_eval_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_action == ACT_EVALUATE) |=> (r_state == S_DIV1))
        else $error("evaluate request did not start the sequence");

    a_load_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_action == ACT_LOAD) |=> (r_state == S_IDLE))
        else $error("load request left idle");

    a_result_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_OUT))
        else $error("result raised outside the output step");

endmodule

[rtl/core/iwsb_dp.sv]
// Datapath: configuration, angle wrap, phase, slot table lookup and blend lanes.
module iwsb_dp import iwsb_pkg::*; #(
    parameter int MAX_SLOTS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cmd                       i_cmd,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_W-1:0]           i_cfg_wdata,
    input  logic signed [ANG_W-1:0]    i_angle,
    input  logic [POS_W-1:0]           i_slot_position,
    input  logic [NUM_W-1:0]           i_slot_number,
    input  logic [CH_W-1:0]            i_red_in,
    input  logic [CH_W-1:0]            i_green_in,
    input  logic [CH_W-1:0]            i_blue_in,
    input  logic [CH_W-1:0]            i_gain_in,
    output logic                       o_valid_res,
    output logic [PH_W-1:0]            o_phase,
    output logic [WRAP_W-1:0]          o_boundary_angle,
    output logic [NUM_W-1:0]           o_first_slot,
    output logic [NUM_W-1:0]           o_second_slot,
    output logic [PH_W-1:0]            o_split,
    output logic [CH_W-1:0]            o_red_out,
    output logic [CH_W-1:0]            o_green_out,
    output logic [CH_W-1:0]            o_blue_out,
    output logic [CH_W-1:0]            o_gain_out
);

    localparam int AW = $clog2(MAX_SLOTS);
    localparam int PW = (AW > POS_W) ? AW : POS_W;
    localparam int BW = (AW > CNT_W) ? AW : CNT_W;

    // Configuration registers
    logic [CNT_W-1:0]        r_slot_count;
    logic signed [OFS_W-1:0] r_offset;
    logic [CNT_W-1:0]        count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_count <= '0;
            r_offset     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SLOT_COUNT:       r_slot_count <= i_cfg_wdata[CNT_W-1:0];
                CFG_PLACEMENT_OFFSET: r_offset     <= signed'(i_cfg_wdata);
                default: ;
            endcase
        end
    end

    assign count = (32'(r_slot_count) > MAX_SLOTS) ? CNT_W'(MAX_SLOTS) : r_slot_count;

    // Slot table
    logic [PW-1:0] pos_ext;
    logic          tbl_we;
    t_slot         wr_ent;
    t_slot         rd_a;
    t_slot         rd_b;
    logic [AW-1:0] raddr_a;
    logic [AW-1:0] raddr_b;

    assign pos_ext = PW'(i_slot_position);
    // drop loads beyond the table
    assign tbl_we  = i_cmd.write_slot && (32'(i_slot_position) < MAX_SLOTS);
    assign wr_ent  = '{number: i_slot_number, red: i_red_in, green: i_green_in,
                       blue: i_blue_in, gain: i_gain_in};

    iwsb_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (MAX_SLOTS)
    ) u_table (
        .i_clk     (i_clk),
        .i_we      (tbl_we),
        .i_waddr   (pos_ext[AW-1:0]),
        .i_wdata   (wr_ent),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    // Offset add
    logic signed [SUM_W-1:0] r_sum;
    logic signed [SUM_W-1:0] n_sum;

    assign n_sum = SUM_W'(i_angle) + SUM_W'(r_offset);

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept_eval) begin
            r_sum <= n_sum;
        end
    end

    // Wrap: low 9 bits pass, high part is reduced modulo 45 after biasing positive
    logic [X_W-1:0]     xb;
    logic [PROD1_W-1:0] r_prod1;
    logic [Q1_W-1:0]    q1;
    logic [X_W-1:0]     t1;
    logic [X_W-1:0]     r1;
    logic [WRAP_W-1:0]  r_wrapped;

    assign xb = X_W'($signed(r_sum[SUM_W-1:LOW_W])) + X_BIAS;
    assign q1 = r_prod1[RECIP1_SH +: Q1_W];
    assign t1 = xb - X_W'(X_W'(q1) * X_W'(DIV_BASE));
    assign r1 = (t1 >= X_W'(DIV_BASE)) ? (t1 - X_W'(DIV_BASE)) : t1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.div1) begin
            r_prod1 <= PROD1_W'(xb) * PROD1_W'(RECIP1);
        end
        if (i_cmd.rem1) begin
            r_wrapped <= {r1[REM_W-1:0], r_sum[LOW_W-1:0]};
        end
    end

    // Phase = floor(wrapped * 128 / 45)
    logic [V_W-1:0]     v;
    logic [PROD2_W-1:0] r_prod2;
    logic [PH_W-1:0]    q2;
    logic [V_W-1:0]     t2;
    logic [PH_W-1:0]    r_phase;

    assign v  = {r_wrapped, 7'b0};
    assign q2 = r_prod2[RECIP2_SH +: PH_W];
    assign t2 = v - V_W'(V_W'(q2) * V_W'(DIV_BASE));

    always_ff @(posedge i_clk) begin
        if (i_cmd.div2) begin
            r_prod2 <= PROD2_W'(v) * PROD2_W'(RECIP2);
        end
        if (i_cmd.rem2) begin
            r_phase <= (t2 >= V_W'(DIV_BASE)) ? (q2 + 1'b1) : q2;
        end
    end

    // Scale by slot count, pick neighbouring slots
    logic [COORD_W-1:0] r_coord;
    logic [CNT_W-1:0]   base_full;
    logic [CNT_W-1:0]   base_inc;
    logic [CNT_W-1:0]   next_full;
    logic [BW-1:0]      base_ext;
    logic [BW-1:0]      next_ext;
    logic [PH_W-1:0]    split;

    assign base_full = r_coord[COORD_W-1:PH_W];
    assign split     = r_coord[PH_W-1:0];
    assign base_inc  = base_full + 1'b1;
    // wrap around the wheel
    assign next_full = (base_inc == count) ? '0 : base_inc;
    assign base_ext  = BW'(base_full);
    assign next_ext  = BW'(next_full);
    assign raddr_a   = base_ext[AW-1:0];
    assign raddr_b   = next_ext[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.scale) begin
            r_coord <= COORD_W'(r_phase) * COORD_W'(count);
        end
    end

    // Blend lanes: a + round((b - a) * split / 65536)
    logic [CH_W-1:0]         ch_a [NUM_CH];
    logic [CH_W-1:0]         ch_b [NUM_CH];
    logic signed [BPR_W-1:0] r_bprod [NUM_CH];
    logic [CH_W-1:0]         blend [NUM_CH];

    assign ch_a[0] = rd_a.red;
    assign ch_a[1] = rd_a.green;
    assign ch_a[2] = rd_a.blue;
    assign ch_a[3] = rd_a.gain;
    assign ch_b[0] = rd_b.red;
    assign ch_b[1] = rd_b.green;
    assign ch_b[2] = rd_b.blue;
    assign ch_b[3] = rd_b.gain;

    for (genvar k = 0; k < NUM_CH; k++) begin : g_lane
        logic signed [D_W-1:0]   diff;
        logic signed [BPR_W-1:0] rnd;
        logic signed [D_W+1:0]   sum;

        assign diff = $signed({1'b0, ch_b[k]}) - $signed({1'b0, ch_a[k]});
        assign rnd  = r_bprod[k] + BPR_W'(32'sd32768);
        assign sum  = $signed({2'b00, ch_a[k]}) + (D_W+2)'(rnd[BPR_W-1:PH_W]);
        assign blend[k] = sum[CH_W-1:0];

        always_ff @(posedge i_clk) begin
            if (i_cmd.mul) begin
                r_bprod[k] <= BPR_W'(diff) * $signed({{(BPR_W-PH_W){1'b0}}, split});
            end
        end
    end

    // Output register; zero slots gives an all-zero result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            if (count == '0) begin
                o_valid_res      <= 1'b0;
                o_phase          <= '0;
                o_boundary_angle <= '0;
                o_first_slot     <= '0;
                o_second_slot    <= '0;
                o_split          <= '0;
                o_red_out        <= '0;
                o_green_out      <= '0;
                o_blue_out       <= '0;
                o_gain_out       <= '0;
            end else begin
                o_valid_res      <= 1'b1;
                o_phase          <= r_phase;
                o_boundary_angle <= r_wrapped;
                o_first_slot     <= rd_a.number;
                o_second_slot    <= rd_b.number;
                o_split          <= split;
                o_red_out        <= blend[0];
                o_green_out      <= blend[1];
                o_blue_out       <= blend[2];
                o_gain_out       <= blend[3];
            end
        end
    end

    a_wrap_in_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.rem1) |-> (r_wrapped < WRAP_W'(TURN_UNITS)))
        else $error("wrapped angle outside one turn");

    a_base_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_cmd.scale) && count != '0) |-> (base_full < count))
        else $error("first slot index beyond slot count");

endmodule

[rtl/core/indexed_wheel_slot_blend_top.sv]
// An evaluate request is taken only in idle, and the next request waits until its result
// is loaded into the output register, which a held-off result ready can stall; a load request
// is written to the slot table while the controller stays idle. The controller walks each
// request through the shared wrap, phase, scale, table-read and blend steps one at a time.
// Synchronous active-low reset clears the controller, output valid and config;
// the slot table holds undefined contents until loaded.
module indexed_wheel_slot_blend_top import iwsb_pkg::*; #(
    parameter int MAX_SLOTS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic                    i_action,
    input  logic signed [ANG_W-1:0] i_angle,
    input  logic [POS_W-1:0]        i_slot_position,
    input  logic [NUM_W-1:0]        i_slot_number,
    input  logic [CH_W-1:0]         i_red_in,
    input  logic [CH_W-1:0]         i_green_in,
    input  logic [CH_W-1:0]         i_blue_in,
    input  logic [CH_W-1:0]         i_gain_in,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic                    o_valid_res,
    output logic [PH_W-1:0]         o_phase,
    output logic [WRAP_W-1:0]       o_boundary_angle,
    output logic [NUM_W-1:0]        o_first_slot,
    output logic [NUM_W-1:0]        o_second_slot,
    output logic [PH_W-1:0]         o_split,
    output logic [CH_W-1:0]         o_red_out,
    output logic [CH_W-1:0]         o_green_out,
    output logic [CH_W-1:0]         o_blue_out,
    output logic [CH_W-1:0]         o_gain_out,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_wdata
);

    t_cmd cmd;

    iwsb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_action    (i_action),
        .o_ready     (o_ready),
        .o_valid     (o_valid),
        .i_out_ready (i_ready),
        .o_cmd       (cmd)
    );

    iwsb_dp #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_angle          (i_angle),
        .i_slot_position  (i_slot_position),
        .i_slot_number    (i_slot_number),
        .i_red_in         (i_red_in),
        .i_green_in       (i_green_in),
        .i_blue_in        (i_blue_in),
        .i_gain_in        (i_gain_in),
        .o_valid_res      (o_valid_res),
        .o_phase          (o_phase),
        .o_boundary_angle (o_boundary_angle),
        .o_first_slot     (o_first_slot),
        .o_second_slot    (o_second_slot),
        .o_split          (o_split),
        .o_red_out        (o_red_out),
        .o_green_out      (o_green_out),
        .o_blue_out       (o_blue_out),
        .o_gain_out       (o_gain_out)
    );

endmodule

[sim/wheel_blend_checker.sv]
// Checker for the wheel slot blend block: watches the channels, predicts each result, compares.
module wheel_blend_checker import iwsb_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_ready,
    input  logic                    i_action,
    input  logic signed [ANG_W-1:0] i_angle,
    input  logic [POS_W-1:0]        i_slot_position,
    input  logic [NUM_W-1:0]        i_slot_number,
    input  logic [CH_W-1:0]         i_red_in,
    input  logic [CH_W-1:0]         i_green_in,
    input  logic [CH_W-1:0]         i_blue_in,
    input  logic [CH_W-1:0]         i_gain_in,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  logic                    i_valid_res,
    input  logic [PH_W-1:0]         i_phase,
    input  logic [WRAP_W-1:0]       i_boundary_angle,
    input  logic [NUM_W-1:0]        i_first_slot,
    input  logic [NUM_W-1:0]        i_second_slot,
    input  logic [PH_W-1:0]         i_split,
    input  logic [CH_W-1:0]         i_red_out,
    input  logic [CH_W-1:0]         i_green_out,
    input  logic [CH_W-1:0]         i_blue_out,
    input  logic [CH_W-1:0]         i_gain_out,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_wdata,
    output int                      o_fail_count,
    output int                      o_pending
);

    localparam int TABLE_DEPTH = 16;
    localparam int PRINT_CAP   = 40;

    typedef struct packed {
        logic              valid_res;
        logic [PH_W-1:0]   phase;
        logic [WRAP_W-1:0] boundary;
        logic [NUM_W-1:0]  first;
        logic [NUM_W-1:0]  second;
        logic [PH_W-1:0]   split;
        logic [CH_W-1:0]   red;
        logic [CH_W-1:0]   green;
        logic [CH_W-1:0]   blue;
        logic [CH_W-1:0]   gain;
    } t_blend;

    logic [CNT_W-1:0]        slot_count_q;
    logic signed [OFS_W-1:0] offset_q;
    t_slot                   slot_tab [TABLE_DEPTH];
    t_blend                  due_blends [$];
    int                      fails;

    initial begin
        fails        = 0;
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic logic [CH_W-1:0] mix_channel(input logic [CH_W-1:0] a,
                                                    input logic [CH_W-1:0] b,
                                                    input logic [31:0] frac);
        logic [63:0] acc;
        acc = 64'(a) * (64'd65536 - 64'(frac)) + 64'(b) * 64'(frac) + 64'd32768;
        return acc[31:16];
    endfunction

    function automatic t_blend blend_at_angle(input logic signed [ANG_W-1:0] ang);
        t_blend      res;
        longint      total;
        longint      w;
        logic [31:0] count;
        logic [31:0] wrapped;
        logic [31:0] ph;
        logic [31:0] coord;
        logic [31:0] base;
        logic [31:0] next;
        logic [31:0] frac;
        res   = '0;
        count = (slot_count_q > TABLE_DEPTH) ? 32'(TABLE_DEPTH) : 32'(slot_count_q);
        if (count == 0) return res;
        total = longint'(ang) + longint'(offset_q);
        w = total % TURN_UNITS;
        if (w < 0) w = w + TURN_UNITS;
        wrapped = 32'(w);
        ph      = (wrapped * 32'd65536) / 32'(TURN_UNITS);
        coord   = ph * count;
        base    = (coord >> 16) % count;
        next    = (base + 1) % count;
        frac    = coord & 32'hFFFF;
        res.valid_res = 1'b1;
        res.phase     = ph[PH_W-1:0];
        res.boundary  = wrapped[WRAP_W-1:0];
        res.first     = slot_tab[base].number;
        res.second    = slot_tab[next].number;
        res.split     = frac[PH_W-1:0];
        res.red       = mix_channel(slot_tab[base].red, slot_tab[next].red, frac);
        res.green     = mix_channel(slot_tab[base].green, slot_tab[next].green, frac);
        res.blue      = mix_channel(slot_tab[base].blue, slot_tab[next].blue, frac);
        res.gain      = mix_channel(slot_tab[base].gain, slot_tab[next].gain, frac);
        return res;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (fails < PRINT_CAP)
            $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
        fails++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) flag_mismatch(what, got, want);
    endtask

    always @(posedge i_clk) begin
        t_blend want;
        if (!i_rst_n) begin
            slot_count_q = '0;
            offset_q     = '0;
            for (int k = 0; k < TABLE_DEPTH; k++) slot_tab[k] = '0;
            due_blends.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SLOT_COUNT:       slot_count_q = i_cfg_wdata[CNT_W-1:0];
                    CFG_PLACEMENT_OFFSET: offset_q     = i_cfg_wdata[OFS_W-1:0];
                    default: ;
                endcase
            end
            // retire before predicting so a stray result is never matched to a fresh request
            if (i_out_valid && i_out_ready) begin
                if (due_blends.size() == 0) begin
                    flag_mismatch("result with none pending, phase", 32'(i_phase), 32'd0);
                end else begin
                    want = due_blends.pop_front();
                    check_field("valid_res", 32'(i_valid_res), 32'(want.valid_res));
                    check_field("phase", 32'(i_phase), 32'(want.phase));
                    check_field("boundary_angle", 32'(i_boundary_angle), 32'(want.boundary));
                    check_field("first_slot", 32'(i_first_slot), 32'(want.first));
                    check_field("second_slot", 32'(i_second_slot), 32'(want.second));
                    check_field("split", 32'(i_split), 32'(want.split));
                    check_field("red_out", 32'(i_red_out), 32'(want.red));
                    check_field("green_out", 32'(i_green_out), 32'(want.green));
                    check_field("blue_out", 32'(i_blue_out), 32'(want.blue));
                    check_field("gain_out", 32'(i_gain_out), 32'(want.gain));
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_action == ACT_LOAD) begin
                    slot_tab[i_slot_position] = '{number: i_slot_number, red: i_red_in,
                                                  green: i_green_in, blue: i_blue_in,
                                                  gain: i_gain_in};
                end else begin
                    due_blends.push_back(blend_at_angle(i_angle));
                end
            end
        end
        o_pending    <= due_blends.size();
        o_fail_count <= fails;
    end

endmodule

[sim/testbench.sv]
// Top of the wheel slot blend testbench: clock, reset, request and result traffic, verdict.
module testbench;
    import iwsb_pkg::*;

    localparam int HOLD_CYCLES  = 250;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 112;
    localparam int SETTLE_TAIL  = 12;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_ready;
    logic                    i_action;
    logic signed [ANG_W-1:0] i_angle;
    logic [POS_W-1:0]        i_slot_position;
    logic [NUM_W-1:0]        i_slot_number;
    logic [CH_W-1:0]         i_red_in;
    logic [CH_W-1:0]         i_green_in;
    logic [CH_W-1:0]         i_blue_in;
    logic [CH_W-1:0]         i_gain_in;
    logic                    o_valid;
    logic                    i_ready;
    logic                    o_valid_res;
    logic [PH_W-1:0]         o_phase;
    logic [WRAP_W-1:0]       o_boundary_angle;
    logic [NUM_W-1:0]        o_first_slot;
    logic [NUM_W-1:0]        o_second_slot;
    logic [PH_W-1:0]         o_split;
    logic [CH_W-1:0]         o_red_out;
    logic [CH_W-1:0]         o_green_out;
    logic [CH_W-1:0]         o_blue_out;
    logic [CH_W-1:0]         o_gain_out;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [CFG_W-1:0]        i_cfg_wdata;

    int   fail_count;
    int   blends_due;
    logic idle_on;
    logic hold_req;

    always #6 i_clk = ~i_clk;

    indexed_wheel_slot_blend_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_action(i_action), .i_angle(i_angle), .i_slot_position(i_slot_position),
        .i_slot_number(i_slot_number), .i_red_in(i_red_in), .i_green_in(i_green_in),
        .i_blue_in(i_blue_in), .i_gain_in(i_gain_in),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_valid_res(o_valid_res), .o_phase(o_phase), .o_boundary_angle(o_boundary_angle),
        .o_first_slot(o_first_slot), .o_second_slot(o_second_slot), .o_split(o_split),
        .o_red_out(o_red_out), .o_green_out(o_green_out), .o_blue_out(o_blue_out),
        .o_gain_out(o_gain_out),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_wdata(i_cfg_wdata)
    );

    wheel_blend_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_valid), .i_in_ready(o_ready),
        .i_action(i_action), .i_angle(i_angle), .i_slot_position(i_slot_position),
        .i_slot_number(i_slot_number), .i_red_in(i_red_in), .i_green_in(i_green_in),
        .i_blue_in(i_blue_in), .i_gain_in(i_gain_in),
        .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_valid_res(o_valid_res), .i_phase(o_phase), .i_boundary_angle(o_boundary_angle),
        .i_first_slot(o_first_slot), .i_second_slot(o_second_slot), .i_split(o_split),
        .i_red_out(o_red_out), .i_green_out(o_green_out), .i_blue_out(o_blue_out),
        .i_gain_out(o_gain_out),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_wdata(i_cfg_wdata),
        .o_fail_count(fail_count), .o_pending(blends_due)
    );

    // Result side: random stalls, plus one long hold-off on request
    initial begin
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req <= 1'b0;
                i_ready  <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_ready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin
        #5_000_000;
        $display("** indexed_wheel_slot_blend_top: FAILED **");
        $finish;
    end

    // Offer one request and return at the edge where it is taken; valid stays high.
    task automatic offer_request(input logic act, input logic signed [ANG_W-1:0] ang,
                                 input logic [POS_W-1:0] pos, input logic [NUM_W-1:0] num,
                                 input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                                 input logic [CH_W-1:0] b, input logic [CH_W-1:0] k);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_action        <= act;
        i_angle         <= ang;
        i_slot_position <= pos;
        i_slot_number   <= num;
        i_red_in        <= r;
        i_green_in      <= g;
        i_blue_in       <= b;
        i_gain_in       <= k;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic evaluate_at(input logic signed [ANG_W-1:0] ang);
        offer_request(ACT_EVALUATE, ang, POS_W'($urandom), NUM_W'($urandom),
                      CH_W'($urandom), CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
    endtask

    // Drop valid and wait until every result is back and the block has gone quiet.
    task automatic settle_block();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (blends_due != 0) @(posedge i_clk);
        repeat (SETTLE_TAIL) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [CNT_W-1:0] count, input int offset);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_SLOT_COUNT;
        i_cfg_wdata <= CFG_W'(count);
        @(posedge i_clk);
        i_cfg_index <= CFG_PLACEMENT_OFFSET;
        i_cfg_wdata <= CFG_W'(offset);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [CH_W-1:0] pick_channel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return CH_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [ANG_W-1:0] pick_angle();
        int turns;
        case ($urandom_range(0, 5))
            0: return ANG_W'(int'($urandom_range(0, 92160)) - 46080);
            1: begin
                turns = int'($urandom_range(0, 180000)) - 90000;
                return ANG_W'(turns * TURN_UNITS + int'($urandom_range(0, 2)) - 1);
            end
            2: return $urandom_range(0, 1) ? ANG_W'(32'h7FFF_FFFF - $urandom_range(0, 3))
                                           : ANG_W'(32'h8000_0000 + $urandom_range(0, 3));
            default: return ANG_W'($urandom);
        endcase
    endfunction

    task automatic random_request();
        if ($urandom_range(0, 9) < 3)
            offer_request(ACT_LOAD, ANG_W'($urandom), POS_W'($urandom), NUM_W'($urandom),
                          pick_channel(), pick_channel(), pick_channel(), pick_channel());
        else
            evaluate_at(pick_angle());
    endtask

    initial begin
        logic [CNT_W-1:0] count_plan  [PHASES];
        int               offset_plan [PHASES];
        logic [POS_W-1:0] p;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_action        = ACT_EVALUATE;
        i_angle         = '0;
        i_slot_position = '0;
        i_slot_number   = '0;
        i_red_in        = '0;
        i_green_in      = '0;
        i_blue_in       = '0;
        i_gain_in       = '0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = CFG_SLOT_COUNT;
        i_cfg_wdata     = '0;
        idle_on         = 1'b1;
        hold_req        = 1'b0;
        count_plan  = '{5'd1, 5'd16, 5'd2, 5'd31, 5'd0, 5'd7, 5'd17,
                        CNT_W'($urandom_range(0, 31))};
        offset_plan = '{-TURN_UNITS, TURN_UNITS, 32767, -32768, 0,
                        int'($urandom_range(0, 46080)) - TURN_UNITS,
                        int'($urandom_range(0, 65535)) - 32768,
                        int'($urandom_range(0, 46080)) - TURN_UNITS};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero slots out of reset: all-zero result, table contents not used
        evaluate_at('0);
        evaluate_at(ANG_W'(32'h8000_0000));

        // Fill the whole table; positions 3 and 4 share a slot number
        for (int k = 0; k < 16; k++) begin
            p = POS_W'(k);
            offer_request(ACT_LOAD, '0, p,
                          (k == 4) ? NUM_W'(4) : ((k == 15) ? NUM_W'(255) : NUM_W'(k + 1)),
                          p[0] ? CH_W'(16'hFFFF) : CH_W'(0),
                          p[0] ? CH_W'(0) : CH_W'(16'hFFFF),
                          CH_W'(k * 16'h1111),
                          p[1] ? CH_W'(16'hFFFF) : CH_W'(16'h0100));
        end
        settle_block();

        write_config(5'd16, 0);
        evaluate_at(ANG_W'(32'h8000_0000));
        evaluate_at(ANG_W'(32'h7FFF_FFFF));
        evaluate_at('0);
        evaluate_at(ANG_W'(TURN_UNITS - 1));
        evaluate_at(ANG_W'(TURN_UNITS));
        evaluate_at(ANG_W'(-1));
        settle_block();

        // Count above the table size saturates
        write_config(5'd31, -32768);
        evaluate_at(ANG_W'(32767));
        settle_block();

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph >= PHASES - 2) idle_on = 1'b0;
            write_config(count_plan[ph], offset_plan[ph]);
            if (ph == 2) hold_req <= 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) random_request();
            settle_block();
        end

        if (fail_count == 0) begin
            $display("** indexed_wheel_slot_blend_top: PASSED **");
        end else begin
            $display("** indexed_wheel_slot_blend_top: FAILED **");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/iwsb_pkg.sv
rtl/core/iwsb_ram.sv
rtl/core/iwsb_ctrl.sv
rtl/core/iwsb_dp.sv
rtl/core/indexed_wheel_slot_blend_top.sv
sim/wheel_blend_checker.sv
sim/testbench.sv
